[design/assert_macros.svh]
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that an antecedent on one edge implies a consequent on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// stbs_pkg
// Types and constants shared by the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int CNT_W = 8;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic [POS_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] data_value;
  } req_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
  } rsp_item_t;

  // Outcome of one probe step over the live range [lo, hi).
  typedef struct packed {
    logic             empty;
    logic             hit;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] lo_next;
    logic [CNT_W-1:0] hi_next;
  } probe_res_t;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_ISSUE   = 4'b0010,
    S_COMPARE = 4'b0100,
    S_RESULT  = 4'b1000
  } state_t;

endpackage

[design/stbs_probe.sv]
// ----------------------------------------------------------------------------
// stbs_probe
// Shared probe unit: midpoint of the live range, key compare and range update.
// ----------------------------------------------------------------------------
module stbs_probe (
  input  logic [stbs_pkg::CNT_W-1:0]        lo,
  input  logic [stbs_pkg::CNT_W-1:0]        hi,
  input  logic signed [stbs_pkg::VAL_W-1:0] key,
  input  logic signed [stbs_pkg::VAL_W-1:0] entry,
  output stbs_pkg::probe_res_t              res
);

  logic [stbs_pkg::CNT_W:0]   mid_sum;
  logic [stbs_pkg::CNT_W-1:0] mid;
  logic                       below;

  // Floor midpoint of the inclusive range lo to hi-1; only used when lo < hi.
  assign mid_sum = {1'b0, lo} + {1'b0, hi} - {{stbs_pkg::CNT_W{1'b0}}, 1'b1};
  assign mid     = mid_sum[stbs_pkg::CNT_W:1];
  assign below   = key < entry;

  always_comb begin
    res.empty   = lo >= hi;
    res.hit     = key == entry;
    res.mid     = mid;
    res.lo_next = below ? lo : mid + {{(stbs_pkg::CNT_W-1){1'b0}}, 1'b1};
    res.hi_next = below ? mid : hi;
  end

endmodule

[design/sorted_table_binary_search_top.sv]
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Sorted table of signed words with a binary search over the entries in use.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                Beat contents
//  req      in         req_valid / req_ready    cmd, entry_index, data_value
//  rsp      out        rsp_valid / rsp_ready    found, match_position
//  cfg      in         cfg_wr_en                element_count
//
//  A write beat leaves the block in its idle state; the block is ready again on the next cycle.
//  A search with P probes, P at most floor(log2(count))+1, is busy through P
//  ISSUE/COMPARE pairs, one more ISSUE on a miss, then RESULT: each probe is
//  one table read with registered data followed by one compare.
//  Synchronous reset clears the sequencer, the response valid flag and the count.
//  A stalled response does not block a new request unless a search finishes
//  while the previous response is still waiting.
module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  stbs_pkg::req_item_t        req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output stbs_pkg::rsp_item_t        rsp,
  input  logic                       cfg_wr_en,
  input  logic [stbs_pkg::CNT_W-1:0] cfg_wr_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic signed [stbs_pkg::VAL_W-1:0] table_mem [TABLE_DEPTH];
  logic signed [stbs_pkg::VAL_W-1:0] rd_data;
  logic [AW-1:0]                     rd_addr;

  stbs_pkg::state_t                  state, state_next;
  logic [stbs_pkg::CNT_W-1:0]        element_count;
  logic [stbs_pkg::CNT_W-1:0]        span;
  logic [stbs_pkg::CNT_W-1:0]        lo, hi;
  logic signed [stbs_pkg::VAL_W-1:0] key;
  logic                              found;
  logic [stbs_pkg::POS_W-1:0]        position;
  stbs_pkg::probe_res_t              probe;

  logic req_fire, wr_fire, search_fire, rsp_load;

  assign req_ready   = state == stbs_pkg::S_IDLE;
  assign req_fire    = req_valid && req_ready;
  assign wr_fire     = req_fire && req.cmd == stbs_pkg::CMD_WRITE &&
                       32'(req.entry_index) < 32'(TABLE_DEPTH);
  assign search_fire = req_fire && req.cmd == stbs_pkg::CMD_SEARCH;
  assign rsp_load    = state == stbs_pkg::S_RESULT && (!rsp_valid || rsp_ready);

  // A count above the table size searches the whole table.
  assign span = (32'(element_count) > 32'(TABLE_DEPTH)) ?
                stbs_pkg::CNT_W'(TABLE_DEPTH) : element_count;

  stbs_probe u_probe (
    .lo    (lo),
    .hi    (hi),
    .key   (key),
    .entry (rd_data),
    .res   (probe)
  );

  assign rd_addr = AW'(probe.mid);

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      table_mem[AW'(req.entry_index)] <= req.data_value;
    end
    rd_data <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else if (cfg_wr_en) begin
      element_count <= cfg_wr_data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      stbs_pkg::S_IDLE: begin
        if (search_fire) state_next = stbs_pkg::S_ISSUE;
      end
      stbs_pkg::S_ISSUE: begin
        state_next = probe.empty ? stbs_pkg::S_RESULT : stbs_pkg::S_COMPARE;
      end
      stbs_pkg::S_COMPARE: begin
        state_next = probe.hit ? stbs_pkg::S_RESULT : stbs_pkg::S_ISSUE;
      end
      stbs_pkg::S_RESULT: begin
        if (rsp_load) state_next = stbs_pkg::S_IDLE;
      end
      default: state_next = stbs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stbs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search datapath: range bounds, key and the pending outcome.
  always_ff @(posedge clk) begin
    if (search_fire) begin
      key      <= req.data_value;
      lo       <= '0;
      hi       <= span;
      found    <= 1'b0;
      position <= '0;
    end else if (state == stbs_pkg::S_COMPARE) begin
      if (probe.hit) begin
        found    <= 1'b1;
        position <= stbs_pkg::POS_W'(probe.mid);
      end else begin
        lo <= probe.lo_next;
        hi <= probe.hi_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.found          <= found;
      rsp.match_position <= position;
    end
  end

endmodule

[design/stbs_checker.sv]
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks for the sorted table binary search block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stbs_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input stbs_pkg::req_item_t req,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input stbs_pkg::rsp_item_t rsp
);

  logic search_beat, write_beat, miss_ok;

  assign search_beat = req_valid && req_ready && req.cmd == stbs_pkg::CMD_SEARCH;
  assign write_beat  = req_valid && req_ready && req.cmd == stbs_pkg::CMD_WRITE;
  assign miss_ok     = !rsp_valid || rsp.found || rsp.match_position == '0;

  // A stalled response beat holds.
  `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp beat moved")

  // A search occupies the block for at least the cycle after it is taken.
  `ASSERT_NEXT(a_search_busy, search_beat, !req_ready, "ready right after a search beat")

  // A table write never makes the block busy.
  `ASSERT_NEXT(a_write_ready, write_beat, req_ready, "not ready after a write beat")

  // A miss always reports position zero.
  `ASSERT_ALWAYS(a_miss_pos, miss_ok, "miss with nonzero position")

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (.*);
